FILE: sv/least_squares_poly_fit_unit_defines.svh
// Assertion macros for the least-squares fit unit.
`ifndef LEAST_SQUARES_POLY_FIT_UNIT_DEFINES_SVH
`define LEAST_SQUARES_POLY_FIT_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define LSPF_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
`define LSPF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LSPF_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg)
`define LSPF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

FILE: sv/lspf_pkg.sv
`default_nettype none
package lspf_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 32;
  localparam int IDX_W    = 2;
  localparam int FRAC_W   = 16;

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x;
    logic signed [SAMPLE_W-1:0] y;
    logic                       last;
  } sample_t;

  typedef struct packed {
    logic              start;
    logic signed [63:0] a;
    logic signed [63:0] b;
  } op_req_t;

  typedef struct packed {
    logic              done;
    logic signed [63:0] res;
  } op_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ACC,
    ST_ACC_MUL,
    ST_BUILD,
    ST_PIV_INIT,
    ST_PIV_SCAN,
    ST_SWAP_RD,
    ST_SWAP_WR,
    ST_SWAP_WB,
    ST_CHK,
    ST_ELIM_DIV,
    ST_ELIM_DWAIT,
    ST_ELIM_MUL,
    ST_ELIM_MWAIT,
    ST_ELIM_SUB,
    ST_BS_INIT,
    ST_BS_LOOP,
    ST_BS_MWAIT,
    ST_BS_DWAIT,
    ST_EMIT
  } lspf_state_t;

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? (64'd0 - 64'(v)) : 64'(v);
  endfunction

  function automatic logic signed [63:0] from_mag(input logic neg, input logic [63:0] m,
                                                  input logic over);
    logic [63:0] r;
    r = (over || m[63]) ? 64'h7FFF_FFFF_FFFF_FFFF : m;
    return neg ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sat_sub64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [COEF_W-1:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[COEF_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: sv/least_squares_poly_fit_unit.sv
`default_nettype none
// Least-squares polynomial fit, TERMS coefficients, Q8.8 samples in, Q16.16
// coefficients out. A sample is taken when start is high and busy is low; a
// two-entry queue holds samples while the solver works. Each sample's
// accumulation is paced by the four-pass 32x32 multiplier. A sample marked
// last then starts the solve, paced by an 80-iteration bit-serial divider
// and the multiplier. Results leave on out_valid, one per cycle, TERMS in
// all, and cannot be held off.
module least_squares_poly_fit_unit #(
  parameter int TERMS       = 2,
  parameter int MAX_SAMPLES = 1024
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic signed [lspf_pkg::SAMPLE_W-1:0] in_x_sample,
  input  wire logic signed [lspf_pkg::SAMPLE_W-1:0] in_y_sample,
  input  wire logic                                 in_last_sample,
  output logic                                      out_valid,
  output logic signed [lspf_pkg::COEF_W-1:0]        out_coef_value,
  output logic [lspf_pkg::IDX_W-1:0]                out_coef_index,
  output logic                                      out_coef_last,
  output logic                                      out_singular
);
  import lspf_pkg::*;

  sample_t head;
  logic    head_valid, head_pop;
  op_req_t mul_req, div_req;
  op_rsp_t mul_rsp, div_rsp;

  lspf_front u_front (
    .clk, .rst_n, .start, .busy,
    .in_x_sample, .in_y_sample, .in_last_sample,
    .head, .head_valid, .head_pop
  );

  lspf_mul u_mul (.clk, .rst_n, .req(mul_req), .rsp(mul_rsp));
  lspf_div u_div (.clk, .rst_n, .req(div_req), .rsp(div_rsp));

  lspf_back #(.TERMS(TERMS), .MAX_SAMPLES(MAX_SAMPLES)) u_back (
    .clk, .rst_n,
    .smp(head), .smp_valid(head_valid), .smp_pop(head_pop),
    .mul_req, .mul_rsp, .div_req, .div_rsp,
    .out_valid, .out_coef_value, .out_coef_index, .out_coef_last, .out_singular
  );

endmodule
`default_nettype wire

FILE: sv/lspf_front.sv
`default_nettype none
module lspf_front (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic signed [lspf_pkg::SAMPLE_W-1:0] in_x_sample,
  input  wire logic signed [lspf_pkg::SAMPLE_W-1:0] in_y_sample,
  input  wire logic                                 in_last_sample,
  output lspf_pkg::sample_t                         head,
  output logic                                      head_valid,
  input  wire logic                                 head_pop
);
  import lspf_pkg::*;

  sample_t     q_r [2];
  logic        wr_r, wr_nxt, rd_r, rd_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push;

  assign busy       = (cnt_r == 2'd2);
  assign push       = start && !busy;
  assign head_valid = (cnt_r != 2'd0);
  assign head       = q_r[rd_r];

  always_comb begin
    wr_nxt  = push ? ~wr_r : wr_r;
    rd_nxt  = head_pop ? ~rd_r : rd_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(head_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_r] <= '{x: in_x_sample, y: in_y_sample, last: in_last_sample};
  end

endmodule
`default_nettype wire

FILE: sv/lspf_mul.sv
`default_nettype none
module lspf_mul (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire lspf_pkg::op_req_t req,
  output lspf_pkg::op_rsp_t      rsp
);
  import lspf_pkg::*;

  logic [63:0]  ma_r, mb_r;
  logic [127:0] acc_r, acc_nxt;
  logic [1:0]   step_r;
  logic         busy_r, done_r, neg_r;
  logic [31:0]  ah, bh;
  logic [63:0]  pp;
  logic [127:0] pp_sh;

  always_comb begin
    ah = step_r[1] ? ma_r[63:32] : ma_r[31:0];
    bh = step_r[0] ? mb_r[63:32] : mb_r[31:0];
    pp = 64'(ah) * 64'(bh);
    case (step_r)
      2'd0:    pp_sh = 128'(pp);
      2'd3:    pp_sh = 128'(pp) << 64;
      default: pp_sh = 128'(pp) << 32;
    endcase
    acc_nxt = acc_r + pp_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 2'd0;
    end else begin
      done_r <= busy_r && (step_r == 2'd3);
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= 2'd0;
      end else if (busy_r) begin
        step_r <= step_r + 2'd1;
        if (step_r == 2'd3) busy_r <= 1'b0;
      end
    end
  end

  // accumulator starts at the rounding constant
  always_ff @(posedge clk) begin
    if (req.start) begin
      ma_r  <= mag64(req.a);
      mb_r  <= mag64(req.b);
      neg_r <= req.a[63] != req.b[63];
      acc_r <= 128'h8000;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = from_mag(neg_r, acc_r[79:16], |acc_r[127:80]);

endmodule
`default_nettype wire

FILE: sv/lspf_div.sv
`default_nettype none
module lspf_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire lspf_pkg::op_req_t req,
  output lspf_pkg::op_rsp_t      rsp
);
  import lspf_pkg::*;

  localparam int DVD_W = 64 + FRAC_W;
  localparam int CW    = $clog2(DVD_W);

  logic [63:0]    md_r, rem_r, q_r;
  logic [DVD_W-1:0] dvd_r;
  logic [CW-1:0]  cnt_r;
  logic           busy_r, done_r, neg_r, over_r;
  logic [64:0]    rem_sh;
  logic           ge;

  always_comb begin
    rem_sh = {rem_r, dvd_r[DVD_W-1]};
    ge     = rem_sh >= 65'(md_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DVD_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      md_r   <= mag64(req.b);
      dvd_r  <= {mag64(req.a), {FRAC_W{1'b0}}};
      rem_r  <= '0;
      q_r    <= '0;
      over_r <= 1'b0;
      neg_r  <= req.a[63] != req.b[63];
    end else if (busy_r) begin
      over_r <= over_r | q_r[63];
      q_r    <= {q_r[62:0], ge};
      rem_r  <= ge ? 64'(rem_sh - 65'(md_r)) : rem_sh[63:0];
      dvd_r  <= dvd_r << 1;
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = from_mag(neg_r, q_r, over_r);

endmodule
`default_nettype wire

FILE: sv/lspf_back.sv
`default_nettype none
`include "least_squares_poly_fit_unit_defines.svh"
module lspf_back #(
  parameter int TERMS       = 2,
  parameter int MAX_SAMPLES = 1024
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire lspf_pkg::sample_t                   smp,
  input  wire logic                                smp_valid,
  output logic                                     smp_pop,
  output lspf_pkg::op_req_t                        mul_req,
  input  wire lspf_pkg::op_rsp_t                   mul_rsp,
  output lspf_pkg::op_req_t                        div_req,
  input  wire lspf_pkg::op_rsp_t                   div_rsp,
  output logic                                     out_valid,
  output logic signed [lspf_pkg::COEF_W-1:0]       out_coef_value,
  output logic [lspf_pkg::IDX_W-1:0]               out_coef_index,
  output logic                                     out_coef_last,
  output logic                                     out_singular
);
  import lspf_pkg::*;

  localparam int NPOW = 2 * (TERMS - 1);
  localparam int NCOL = TERMS + 1;
  localparam int NM   = TERMS * NCOL;
  localparam int NACC = NPOW + TERMS;
  localparam int IW   = $clog2(NCOL + 1);
  localparam int AW   = $clog2(NACC);
  localparam int PW   = $clog2(NPOW);
  localparam int EW   = $clog2(TERMS);
  localparam int MW   = $clog2(NM);
  localparam int CNTW = $clog2(MAX_SAMPLES + 1);
  localparam logic [IW-1:0]   TERMS_I = IW'(TERMS);
  localparam logic [IW-1:0]   TLAST_I = IW'(TERMS - 1);
  localparam logic [AW-1:0]   ALAST   = AW'(NACC - 1);
  localparam logic [AW-1:0]   APLAST  = AW'(NPOW - 1);
  localparam logic [CNTW-1:0] CNT_MAX = CNTW'(MAX_SAMPLES);

  lspf_state_t state_r, state_nxt;

  logic signed [63:0] ps_r [NPOW];
  logic signed [63:0] ps_nxt [NPOW];
  logic signed [63:0] ws_r [TERMS];
  logic signed [63:0] ws_nxt [TERMS];
  logic signed [63:0] m_r [NM];
  logic signed [63:0] m_nxt [NM];
  logic signed [63:0] coef_r [TERMS];
  logic signed [63:0] coef_nxt [TERMS];
  logic [CNTW-1:0]    cnt_r, cnt_nxt;
  logic               sing_r, sing_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic [IW-1:0]      k_r, k_nxt, i_r, i_nxt, j_r, j_nxt, p_r, p_nxt;
  logic signed [63:0] pw_r, pw_nxt, xq_r, xq_nxt, yq_r, yq_nxt;
  logic               last_r, last_nxt;
  logic [63:0]        best_r, best_nxt;
  logic signed [63:0] tmp_r, tmp_nxt, piv_r, piv_nxt, mu_r, mu_nxt;
  logic signed [63:0] prod_r, prod_nxt, t_r, t_nxt;

  logic [IW-1:0]      rd_row, rd_col, wr_row, wr_col;
  logic [MW-1:0]      rd_idx, wr_idx;
  logic signed [63:0] rd_data, wr_data;
  logic               wr_en;
  logic               room;

  assign room    = cnt_r < CNT_MAX;
  assign rd_idx  = MW'(int'(rd_row) * NCOL + int'(rd_col));
  assign wr_idx  = MW'(int'(wr_row) * NCOL + int'(wr_col));
  assign rd_data = m_r[rd_idx];

  always_comb begin
    rd_row = '0;
    rd_col = '0;
    case (state_r)
      ST_PIV_INIT, ST_CHK: begin
        rd_row = k_r;
        rd_col = k_r;
      end
      ST_PIV_SCAN, ST_ELIM_DIV: begin
        rd_row = i_r;
        rd_col = k_r;
      end
      ST_SWAP_RD, ST_ELIM_MUL: begin
        rd_row = k_r;
        rd_col = j_r;
      end
      ST_SWAP_WR: begin
        rd_row = p_r;
        rd_col = j_r;
      end
      ST_ELIM_SUB: begin
        rd_row = i_r;
        rd_col = j_r;
      end
      ST_BS_INIT: begin
        rd_row = k_r;
        rd_col = TERMS_I;
      end
      ST_BS_LOOP: begin
        rd_row = k_r;
        rd_col = (j_r < TERMS_I) ? j_r : k_r;
      end
      default: begin
        rd_row = '0;
        rd_col = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (smp_valid) begin
          if (room) state_nxt = ST_ACC;
          else if (smp.last) state_nxt = ST_BUILD;
        end
      end
      ST_ACC: begin
        if (idx_r == ALAST) state_nxt = last_r ? ST_BUILD : ST_IDLE;
        else if (idx_r != APLAST) state_nxt = ST_ACC_MUL;
      end
      ST_ACC_MUL:    if (mul_rsp.done) state_nxt = ST_ACC;
      ST_BUILD:      state_nxt = ST_PIV_INIT;
      ST_PIV_INIT:   state_nxt = ST_PIV_SCAN;
      ST_PIV_SCAN: begin
        if (i_r >= TERMS_I) state_nxt = (p_r != k_r) ? ST_SWAP_RD : ST_CHK;
      end
      ST_SWAP_RD:    state_nxt = ST_SWAP_WR;
      ST_SWAP_WR:    state_nxt = ST_SWAP_WB;
      ST_SWAP_WB:    state_nxt = (j_r == TERMS_I) ? ST_CHK : ST_SWAP_RD;
      ST_CHK:        state_nxt = (rd_data == '0) ? ST_EMIT : ST_ELIM_DIV;
      ST_ELIM_DIV: begin
        if (i_r < TERMS_I) state_nxt = ST_ELIM_DWAIT;
        else state_nxt = (k_r == TLAST_I) ? ST_BS_INIT : ST_PIV_INIT;
      end
      ST_ELIM_DWAIT: if (div_rsp.done) state_nxt = ST_ELIM_MUL;
      ST_ELIM_MUL:   state_nxt = ST_ELIM_MWAIT;
      ST_ELIM_MWAIT: if (mul_rsp.done) state_nxt = ST_ELIM_SUB;
      ST_ELIM_SUB:   state_nxt = (j_r == TERMS_I) ? ST_ELIM_DIV : ST_ELIM_MUL;
      ST_BS_INIT:    state_nxt = ST_BS_LOOP;
      ST_BS_LOOP:    state_nxt = (j_r < TERMS_I) ? ST_BS_MWAIT : ST_BS_DWAIT;
      ST_BS_MWAIT:   if (mul_rsp.done) state_nxt = ST_BS_LOOP;
      ST_BS_DWAIT: begin
        if (div_rsp.done) state_nxt = (k_r == '0) ? ST_EMIT : ST_BS_INIT;
      end
      ST_EMIT:       if (i_r == TLAST_I) state_nxt = ST_IDLE;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ps_nxt   = ps_r;
    ws_nxt   = ws_r;
    m_nxt    = m_r;
    coef_nxt = coef_r;
    cnt_nxt  = cnt_r;
    sing_nxt = sing_r;
    idx_nxt  = idx_r;
    k_nxt    = k_r;
    i_nxt    = i_r;
    j_nxt    = j_r;
    p_nxt    = p_r;
    pw_nxt   = pw_r;
    xq_nxt   = xq_r;
    yq_nxt   = yq_r;
    last_nxt = last_r;
    best_nxt = best_r;
    tmp_nxt  = tmp_r;
    piv_nxt  = piv_r;
    mu_nxt   = mu_r;
    prod_nxt = prod_r;
    t_nxt    = t_r;
    smp_pop  = 1'b0;
    mul_req  = '0;
    div_req  = '0;
    wr_en    = 1'b0;
    wr_row   = '0;
    wr_col   = '0;
    wr_data  = '0;
    out_valid      = 1'b0;
    out_coef_value = '0;
    out_coef_index = '0;
    out_coef_last  = 1'b0;
    out_singular   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (smp_valid) begin
          smp_pop  = 1'b1;
          xq_nxt   = {{40{smp.x[SAMPLE_W-1]}}, smp.x, 8'd0};
          yq_nxt   = {{40{smp.y[SAMPLE_W-1]}}, smp.y, 8'd0};
          pw_nxt   = {{40{smp.x[SAMPLE_W-1]}}, smp.x, 8'd0};
          last_nxt = smp.last;
          idx_nxt  = '0;
        end
      end
      ST_ACC: begin
        if (idx_r < AW'(NPOW)) ps_nxt[idx_r[PW-1:0]] = sat_add64(ps_r[idx_r[PW-1:0]], pw_r);
        else ws_nxt[EW'(idx_r - AW'(NPOW))] = sat_add64(ws_r[EW'(idx_r - AW'(NPOW))], pw_r);
        if (idx_r == ALAST) begin
          cnt_nxt = cnt_r + 1'b1;
        end else if (idx_r == APLAST) begin
          pw_nxt  = yq_r;
          idx_nxt = idx_r + 1'b1;
        end else begin
          mul_req = '{start: 1'b1, a: pw_r, b: xq_r};
        end
      end
      ST_ACC_MUL: begin
        if (mul_rsp.done) begin
          pw_nxt  = mul_rsp.res;
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_BUILD: begin
        for (int r = 0; r < TERMS; r++) begin
          for (int c = 0; c < NCOL; c++) begin
            if (c == TERMS) m_nxt[r * NCOL + c] = ws_r[r];
            else if (r + c == 0) m_nxt[r * NCOL + c] = $signed(64'(cnt_r) << FRAC_W);
            else m_nxt[r * NCOL + c] = ps_r[r + c - 1];
          end
        end
        k_nxt = '0;
      end
      ST_PIV_INIT: begin
        best_nxt = mag64(rd_data);
        p_nxt    = k_r;
        i_nxt    = k_r + 1'b1;
      end
      ST_PIV_SCAN: begin
        if (i_r < TERMS_I) begin
          if (mag64(rd_data) > best_r) begin
            best_nxt = mag64(rd_data);
            p_nxt    = i_r;
          end
          i_nxt = i_r + 1'b1;
        end else begin
          j_nxt = '0;
        end
      end
      ST_SWAP_RD: tmp_nxt = rd_data;
      ST_SWAP_WR: begin
        wr_en   = 1'b1;
        wr_row  = k_r;
        wr_col  = j_r;
        wr_data = rd_data;
      end
      ST_SWAP_WB: begin
        wr_en   = 1'b1;
        wr_row  = p_r;
        wr_col  = j_r;
        wr_data = tmp_r;
        j_nxt   = j_r + 1'b1;
      end
      ST_CHK: begin
        piv_nxt = rd_data;
        i_nxt   = (rd_data == '0) ? '0 : k_r + 1'b1;
        if (rd_data == '0) sing_nxt = 1'b1;
      end
      ST_ELIM_DIV: begin
        if (i_r < TERMS_I) div_req = '{start: 1'b1, a: rd_data, b: piv_r};
        else if (k_r != TLAST_I) k_nxt = k_r + 1'b1;
      end
      ST_ELIM_DWAIT: begin
        if (div_rsp.done) begin
          mu_nxt = div_rsp.res;
          j_nxt  = k_r + 1'b1;
        end
      end
      ST_ELIM_MUL: mul_req = '{start: 1'b1, a: mu_r, b: rd_data};
      ST_ELIM_MWAIT: if (mul_rsp.done) prod_nxt = mul_rsp.res;
      ST_ELIM_SUB: begin
        wr_en   = 1'b1;
        wr_row  = i_r;
        wr_col  = j_r;
        wr_data = sat_sub64(rd_data, prod_r);
        if (j_r == TERMS_I) i_nxt = i_r + 1'b1;
        else j_nxt = j_r + 1'b1;
      end
      ST_BS_INIT: begin
        t_nxt = rd_data;
        j_nxt = k_r + 1'b1;
      end
      ST_BS_LOOP: begin
        if (j_r < TERMS_I) mul_req = '{start: 1'b1, a: rd_data, b: coef_r[j_r[EW-1:0]]};
        else div_req = '{start: 1'b1, a: t_r, b: rd_data};
      end
      ST_BS_MWAIT: begin
        if (mul_rsp.done) begin
          t_nxt = sat_sub64(t_r, mul_rsp.res);
          j_nxt = j_r + 1'b1;
        end
      end
      ST_BS_DWAIT: begin
        if (div_rsp.done) begin
          coef_nxt[k_r[EW-1:0]] = div_rsp.res;
          if (k_r != '0) k_nxt = k_r - 1'b1;
          i_nxt = '0;
        end
      end
      ST_EMIT: begin
        out_valid      = 1'b1;
        out_coef_value = sing_r ? '0 : sat32(coef_r[i_r[EW-1:0]]);
        out_coef_index = IDX_W'(i_r);
        out_coef_last  = (i_r == TLAST_I);
        out_singular   = sing_r;
        i_nxt          = i_r + 1'b1;
        if (i_r == TLAST_I) begin
          for (int n = 0; n < NPOW; n++) ps_nxt[n] = '0;
          for (int n = 0; n < TERMS; n++) ws_nxt[n] = '0;
          cnt_nxt  = '0;
          sing_nxt = 1'b0;
        end
      end
      default: smp_pop = 1'b0;
    endcase
    if (wr_en) m_nxt[wr_idx] = wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      sing_r  <= 1'b0;
      for (int n = 0; n < NPOW; n++) ps_r[n] <= '0;
      for (int n = 0; n < TERMS; n++) ws_r[n] <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      sing_r  <= sing_nxt;
      ps_r    <= ps_nxt;
      ws_r    <= ws_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r    <= m_nxt;
    coef_r <= coef_nxt;
    idx_r  <= idx_nxt;
    k_r    <= k_nxt;
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    p_r    <= p_nxt;
    pw_r   <= pw_nxt;
    xq_r   <= xq_nxt;
    yq_r   <= yq_nxt;
    last_r <= last_nxt;
    best_r <= best_nxt;
    tmp_r  <= tmp_nxt;
    piv_r  <= piv_nxt;
    mu_r   <= mu_nxt;
    prod_r <= prod_nxt;
    t_r    <= t_nxt;
  end

  `LSPF_ASSERT_IMPLIES(a_sing_zero, clk, rst_n, out_valid && out_singular, out_coef_value == '0, "singular coefficient not zero")
  `LSPF_ASSERT_NEXT(a_clear_after_run, clk, rst_n, out_valid && out_coef_last, cnt_r == '0 && !sing_r, "sums not cleared after run")
  `LSPF_ASSERT_NEXT(a_run_contiguous, clk, rst_n, out_valid && !out_coef_last, out_valid, "coefficient run broken")
  `LSPF_ASSERT_IMPLIES(a_one_op, clk, rst_n, mul_req.start, !div_req.start, "two arithmetic units started at once")

endmodule
`default_nettype wire

FILE: test/least_squares_poly_fit_unit_checker.sv
`default_nettype none
module least_squares_poly_fit_unit_checker #(
  parameter int TERMS       = 2,
  parameter int MAX_SAMPLES = 1024
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  input  wire logic                                 busy,
  input  wire logic signed [lspf_pkg::SAMPLE_W-1:0] in_x_sample,
  input  wire logic signed [lspf_pkg::SAMPLE_W-1:0] in_y_sample,
  input  wire logic                                 in_last_sample,
  input  wire logic                                 out_valid,
  input  wire logic signed [lspf_pkg::COEF_W-1:0]   out_coef_value,
  input  wire logic [lspf_pkg::IDX_W-1:0]           out_coef_index,
  input  wire logic                                 out_coef_last,
  input  wire logic                                 out_singular,
  output int                                        fail_count,
  output int                                        coefs_pending,
  output int                                        coefs_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPOW = 2 * (TERMS - 1);
  localparam int NCOL = TERMS + 1;
  localparam logic signed [63:0] MAX64 = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] MIN64 = 64'sh8000_0000_0000_0000;

  typedef struct {
    logic signed [lspf_pkg::COEF_W-1:0] value;
    logic [lspf_pkg::IDX_W-1:0]         index;
    logic                               last;
    logic                               singular;
  } coef_t;

  coef_t expected_coefs[$];
  logic signed [63:0] x_pow_sum[NPOW];
  logic signed [63:0] xy_sum[TERMS];
  int sample_total;

  function automatic logic [63:0] magnitude(input logic signed [63:0] v);
    return v[63] ? 64'd0 - v : v;
  endfunction

  function automatic logic signed [63:0] signed_sat(input logic neg, input logic [127:0] m);
    logic [63:0] r;
    r = (m > 128'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : m[63:0];
    return neg ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return MAX64;
    if (s < -65'sh0_8000_0000_0000_0000) return MIN64;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sub_sat(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return MAX64;
    if (s < -65'sh0_8000_0000_0000_0000) return MIN64;
    return s[63:0];
  endfunction

  // Q.16 product, round half away from zero
  function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
    logic [127:0] p;
    p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
    p = (p + 128'h8000) >> 16;
    return signed_sat(a[63] != b[63], p);
  endfunction

  // Q.16 quotient, truncated toward zero
  function automatic logic signed [63:0] fx_div(input logic signed [63:0] n,
                                                input logic signed [63:0] d);
    logic [127:0] q;
    q = ({64'd0, magnitude(n)} << 16) / {64'd0, magnitude(d)};
    return signed_sat(n[63] != d[63], q);
  endfunction

  task automatic accumulate_sample(input logic signed [15:0] xs, input logic signed [15:0] ys);
    logic signed [63:0] xq, pw, w;
    xq = 64'(xs) * 256;
    pw = xq;
    w = 64'(ys) * 256;
    if (sample_total < MAX_SAMPLES) begin
      for (int k = 0; k < NPOW; k++) begin
        x_pow_sum[k] = add_sat(x_pow_sum[k], pw);
        pw = fx_mul(pw, xq);
      end
      for (int k = 0; k < TERMS; k++) begin
        xy_sum[k] = add_sat(xy_sum[k], w);
        w = fx_mul(w, xq);
      end
      sample_total++;
    end
  endtask

  task automatic solve_and_expect();
    logic signed [63:0] m[TERMS][NCOL];
    logic signed [63:0] coef[TERMS];
    logic signed [63:0] t, mu;
    logic [63:0] best;
    logic sing;
    int p;
    coef_t c;
    sing = 0;
    for (int i = 0; i < TERMS; i++) begin
      coef[i] = 0;
      for (int j = 0; j < TERMS; j++)
        m[i][j] = (i + j == 0) ? 64'(sample_total) * 65536 : x_pow_sum[i + j - 1];
      m[i][TERMS] = xy_sum[i];
    end
    for (int k = 0; k < TERMS && !sing; k++) begin
      best = magnitude(m[k][k]);
      p = k;
      for (int i = k + 1; i < TERMS; i++)
        if (magnitude(m[i][k]) > best) begin
          best = magnitude(m[i][k]);
          p = i;
        end
      for (int j = 0; j < NCOL; j++) begin
        t = m[k][j];
        m[k][j] = m[p][j];
        m[p][j] = t;
      end
      if (m[k][k] == 0) sing = 1;
      else
        for (int i = k + 1; i < TERMS; i++) begin
          mu = fx_div(m[i][k], m[k][k]);
          for (int j = k + 1; j < NCOL; j++) m[i][j] = sub_sat(m[i][j], fx_mul(mu, m[k][j]));
          m[i][k] = 0;
        end
    end
    if (!sing)
      for (int k = TERMS - 1; k >= 0; k--) begin
        t = m[k][TERMS];
        for (int j = k + 1; j < TERMS; j++) t = sub_sat(t, fx_mul(m[k][j], coef[j]));
        coef[k] = fx_div(t, m[k][k]);
      end
    for (int k = 0; k < TERMS; k++) begin
      c.value = sing ? '0 : lspf_pkg::sat32(coef[k]);
      c.index = k[lspf_pkg::IDX_W-1:0];
      c.last = (k == TERMS - 1);
      c.singular = sing;
      expected_coefs.push_back(c);
    end
    for (int k = 0; k < NPOW; k++) x_pow_sum[k] = 0;
    for (int k = 0; k < TERMS; k++) xy_sum[k] = 0;
    sample_total = 0;
  endtask

  initial begin
    fail_count = 0;
    coefs_checked = 0;
    sample_total = 0;
    for (int k = 0; k < NPOW; k++) x_pow_sum[k] = 0;
    for (int k = 0; k < TERMS; k++) xy_sum[k] = 0;
  end

  assign coefs_pending = expected_coefs.size();

  always @(posedge clk) begin
    coef_t e;
    if (rst_n && out_valid) begin
      if (expected_coefs.size() == 0) begin
        $display("%0t: unexpected coefficient value=%0d index=%0d", $time,
                 out_coef_value, out_coef_index);
        fail_count++;
      end else begin
        e = expected_coefs.pop_front();
        coefs_checked++;
        if (out_coef_value !== e.value) begin
          $display("%0t: coef_value expected %0d actual %0d", $time, e.value, out_coef_value);
          fail_count++;
        end
        if (out_coef_index !== e.index) begin
          $display("%0t: coef_index expected %0d actual %0d", $time, e.index, out_coef_index);
          fail_count++;
        end
        if (out_coef_last !== e.last) begin
          $display("%0t: coef_last expected %0b actual %0b", $time, e.last, out_coef_last);
          fail_count++;
        end
        if (out_singular !== e.singular) begin
          $display("%0t: singular expected %0b actual %0b", $time, e.singular, out_singular);
          fail_count++;
        end
      end
    end
    if (rst_n && start && !busy) begin
      accumulate_sample(in_x_sample, in_y_sample);
      if (in_last_sample) solve_and_expect();
    end
  end
endmodule
`default_nettype wire

FILE: test/least_squares_poly_fit_unit_tb.sv
`default_nettype none
module least_squares_poly_fit_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TERMS       = 2;
  localparam int MAX_SAMPLES = 1024;

  logic clk, rst_n, start, busy;
  logic signed [lspf_pkg::SAMPLE_W-1:0] in_x_sample, in_y_sample;
  logic in_last_sample, out_valid, out_coef_last, out_singular;
  logic signed [lspf_pkg::COEF_W-1:0] out_coef_value;
  logic [lspf_pkg::IDX_W-1:0] out_coef_index;
  int fail_count, coefs_pending, coefs_checked;
  int idle_pct, sets_sent, samples_sent;

  least_squares_poly_fit_unit #(.TERMS(TERMS), .MAX_SAMPLES(MAX_SAMPLES)) dut (.*);

  least_squares_poly_fit_unit_checker #(.TERMS(TERMS), .MAX_SAMPLES(MAX_SAMPLES)) checker_i (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  task automatic send_sample(input logic [15:0] xs, input logic [15:0] ys, input logic lst);
    start <= 1;
    in_x_sample <= xs;
    in_y_sample <= ys;
    in_last_sample <= lst;
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
    samples_sent++;
    if (lst) sets_sent++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 0;
    @(posedge clk);
    while (coefs_pending != 0) @(posedge clk);
  endtask

  task automatic random_set(input int n, input logic narrow);
    logic [15:0] xs, ys;
    for (int i = 0; i < n; i++) begin
      xs = narrow ? 16'($signed($urandom_range(0, 4095)) - 2048) : 16'($urandom);
      ys = narrow ? 16'($signed($urandom_range(0, 4095)) - 2048) : 16'($urandom);
      send_sample(xs, ys, i == n - 1);
    end
  endtask

  initial begin
    rst_n = 0;
    start = 0;
    in_x_sample = 0;
    in_y_sample = 0;
    in_last_sample = 0;
    idle_pct = 0;
    sets_sent = 0;
    samples_sent = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // single sample: too few to fit
    send_sample(16'h0100, 16'h0200, 1);
    // straight line y = 2x + 1
    send_sample(16'h0000, 16'h0100, 0);
    send_sample(16'h0100, 16'h0300, 0);
    send_sample(16'h0200, 16'h0500, 1);
    // same x twice: zero pivot after elimination
    send_sample(16'h0300, 16'h0100, 0);
    send_sample(16'h0300, 16'hFF00, 1);
    // field extremes, pivot swap from large x
    send_sample(16'h8000, 16'h7FFF, 0);
    send_sample(16'h7FFF, 16'h8000, 0);
    send_sample(16'hFFFF, 16'h0000, 1);
    send_sample(16'h7FFF, 16'h7FFF, 0);
    send_sample(16'h7FFF, 16'h7FFF, 0);
    send_sample(16'h8000, 16'h8000, 1);
    // steep slope, coefficient saturation
    send_sample(16'h0000, 16'h8000, 0);
    send_sample(16'h0001, 16'h7FFF, 1);
    // all zero samples
    send_sample(16'h0000, 16'h0000, 0);
    send_sample(16'h0000, 16'h0000, 1);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 51 : (ph == 2) ? 12 : 0;
      while (samples_sent < 16 + 66 * (ph + 1)) begin
        case ($urandom_range(9))
          0: random_set(1, 1);
          1: random_set($urandom_range(2, 5), 0);
          default: random_set($urandom_range(2, 6), 1);
        endcase
      end
      wait_drained();
    end

    repeat (500) @(posedge clk);
    $display("Covered %0d samples in %0d sets, %0d coefficients checked, with and without gaps",
             samples_sent, sets_sent, coefs_checked);
    if (fail_count == 0 && coefs_pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
`default_nettype wire
